// File: hdl/sfs_pkg.sv
// shared types, constants and register codes for the sprite frame sequencer
package sfs_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int TIME_BITS_DEF  = 16;

  localparam int TILE_W  = 12;
  localparam int COL_W   = 8;
  localparam int PX_W    = 13;
  localparam int CFG_W   = 13;
  localparam int FC_W    = 7;
  localparam int IN_DUR_W = 16;
  localparam int SRCX_W  = 20;
  localparam int SRCY_W  = 24;
  localparam int FRAME_W = 6;
  localparam int MUL_W   = TILE_W + PX_W;
  localparam int DIV_CNT_W = 4;

  localparam logic [PX_W-1:0]  TILE_PX_MAX       = PX_W'(4096);
  localparam logic [FC_W-1:0]  FRAME_COUNT_RST   = '0;
  localparam logic [COL_W-1:0] ATLAS_COLUMNS_RST = COL_W'(1);
  localparam logic [PX_W-1:0]  TILE_WIDTH_RST    = PX_W'(16);
  localparam logic [PX_W-1:0]  TILE_HEIGHT_RST   = PX_W'(16);

  typedef enum logic [1:0] {
    REG_FRAME_COUNT   = 2'd0,
    REG_ATLAS_COLUMNS = 2'd1,
    REG_TILE_WIDTH    = 2'd2,
    REG_TILE_HEIGHT   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [TILE_W-1:0] dividend;
    logic [COL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TILE_W-1:0] quotient;
    logic [COL_W-1:0]  remainder;
  } div_rsp_t;

endpackage

// File: hdl/sfs_ram.sv
// generic single-port-write ram with registered read
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sfs_divider.sv
// iterative restoring divider, one quotient bit per cycle
module sfs_divider (
  input  logic               clk,
  input  logic               rst,
  input  sfs_pkg::div_req_t  req,
  output sfs_pkg::div_rsp_t  rsp
);
  import sfs_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TILE_W-1:0]    quo;
  logic [COL_W-1:0]     rem;
  logic [COL_W-1:0]     dvs;
  logic [COL_W:0]       trial;
  logic                 fits;

  assign trial = {rem, quo[TILE_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= fits ? COL_W'(trial - {1'b0, dvs}) : trial[COL_W-1:0];
        quo <= {quo[TILE_W-2:0], fits};
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(TILE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// File: hdl/atlas_sprite_frame_sequencer_unit.sv
// sprite frame sequencer: frame advance loop, atlas divider and source position
// a frame write is taken while idle; a tick with no frames goes straight to the done state,
//   otherwise it passes read/check once per frame advance, then divide, multiply x, multiply y
// throughput: one tick at a time, set by the compare/subtract loop over the frame ram
//   (a read and a check state per advance) and the 12-step divider for tile column and row
// reset: synchronous, clears the sequencer, frame index, time accumulator and registers;
//   the frame ram is not cleared and a frame must be written before it is shown
module atlas_sprite_frame_sequencer_unit #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  sfs_pkg::cfg_idx_t            cfg_index,
  input  logic [sfs_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic [5:0]                   entry_index,
  input  logic [sfs_pkg::TILE_W-1:0]   entry_tile,
  input  logic [sfs_pkg::IN_DUR_W-1:0] entry_duration,
  input  logic [sfs_pkg::IN_DUR_W-1:0] elapsed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sfs_pkg::FRAME_W-1:0]  frame_now,
  output logic [sfs_pkg::COL_W-1:0]    tile_col,
  output logic [sfs_pkg::TILE_W-1:0]   tile_row,
  output logic [sfs_pkg::SRCX_W-1:0]   src_x,
  output logic [sfs_pkg::SRCY_W-1:0]   src_y,
  output logic                         finished
);
  import sfs_pkg::*;

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (CNT_W > FC_W) ? CNT_W : FC_W;
  localparam int WORD_W = TILE_W + TIME_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DIV,
    S_MULX,
    S_MULY,
    S_DONE
  } state_t;

  state_t state;

  logic [FC_W-1:0]  num_frames;
  logic [COL_W-1:0] atlas_columns;
  logic [PX_W-1:0]  tile_width;
  logic [PX_W-1:0]  tile_height;

  logic [IDX_W-1:0]     cur;
  logic [TIME_BITS:0]   accum;
  logic                 fin;
  logic                 empty;
  logic [SRCX_W-1:0]    px_x;
  logic [SRCY_W-1:0]    px_y;

  logic [CMP_W-1:0]     count_wide;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     cur_ext;
  logic [CNT_W-1:0]     nxt;
  logic                 wrap;
  logic                 accept;
  logic                 tick;
  logic                 ram_we;
  logic [TIME_BITS-1:0] dur_in;
  logic [TIME_BITS-1:0] dur_wr;
  logic [WORD_W-1:0]    ram_rd;
  logic [TIME_BITS-1:0] dur_rd;
  logic [TIME_BITS-1:0] dur_eff;
  logic                 adv;
  logic [TIME_BITS:0]   accum_add;
  logic [COL_W-1:0]     cols;
  logic [PX_W-1:0]      tw_sat;
  logic [PX_W-1:0]      th_sat;
  logic [TILE_W-1:0]    mul_a;
  logic [PX_W-1:0]      mul_b;
  logic [MUL_W-1:0]     prod;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames    <= FRAME_COUNT_RST;
      atlas_columns <= ATLAS_COLUMNS_RST;
      tile_width    <= TILE_WIDTH_RST;
      tile_height   <= TILE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COUNT:   num_frames    <= cfg_data[FC_W-1:0];
        REG_ATLAS_COLUMNS: atlas_columns <= cfg_data[COL_W-1:0];
        REG_TILE_WIDTH:    tile_width    <= cfg_data[PX_W-1:0];
        REG_TILE_HEIGHT:   tile_height   <= cfg_data[PX_W-1:0];
        default: ;
      endcase
    end
  end

  assign count_wide = (CMP_W'(num_frames) > CMP_W'(MAX_FRAMES)) ?
                      CMP_W'(MAX_FRAMES) : CMP_W'(num_frames);
  assign count      = CNT_W'(count_wide);
  assign cur_ext    = CNT_W'(cur);
  assign nxt        = cur_ext + CNT_W'(1);
  assign wrap       = nxt >= count;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign tick     = accept && (cmd == CMD_TICK);

  assign dur_in = TIME_BITS'(entry_duration);
  assign dur_wr = (dur_in == '0) ? TIME_BITS'(1) : dur_in;
  assign ram_we = accept && (cmd == CMD_WRITE) && (32'(entry_index) < 32'(MAX_FRAMES));

  sfs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_FRAMES),
    .AW    (IDX_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(entry_index)),
    .wdata ({entry_tile, dur_wr}),
    .raddr (cur),
    .rdata (ram_rd)
  );

  assign dur_rd    = ram_rd[TIME_BITS-1:0];
  assign dur_eff   = (dur_rd == '0) ? TIME_BITS'(1) : dur_rd;
  assign adv       = accum >= {1'b0, dur_eff};
  assign accum_add = accum + (TIME_BITS + 1)'(TIME_BITS'(elapsed));

  assign cols = (atlas_columns == '0) ? COL_W'(1) : atlas_columns;

  assign div_req.start    = (state == S_CHECK) && !adv;
  assign div_req.dividend = ram_rd[WORD_W-1:TIME_BITS];
  assign div_req.divisor  = cols;

  sfs_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // one multiplier shared by the x and y source positions
  assign tw_sat = (tile_width  > TILE_PX_MAX) ? TILE_PX_MAX : tile_width;
  assign th_sat = (tile_height > TILE_PX_MAX) ? TILE_PX_MAX : tile_height;
  assign mul_a  = (state == S_MULX) ? TILE_W'(div_rsp.remainder) : div_rsp.quotient;
  assign mul_b  = (state == S_MULX) ? tw_sat : th_sat;
  assign prod   = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      accum     <= '0;
      fin       <= 1'b0;
      empty     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick) begin
            fin <= 1'b0;
            if (count == '0) begin
              empty <= 1'b1;
              state <= S_DONE;
            end else begin
              empty <= 1'b0;
              accum <= accum_add;
              if (cur_ext >= count) begin
                cur <= IDX_W'(count - CNT_W'(1));
              end
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (adv) begin
            accum <= accum - {1'b0, dur_eff};
            if (wrap) begin
              cur <= '0;
              fin <= 1'b1;
            end else begin
              cur <= IDX_W'(nxt);
            end
            state <= S_READ;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_MULX;
          end
        end
        S_MULX: begin
          px_x  <= prod[SRCX_W-1:0];
          state <= S_MULY;
        end
        S_MULY: begin
          px_y  <= prod[SRCY_W-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (empty) begin
              frame_now <= '0;
              tile_col  <= '0;
              tile_row  <= '0;
              src_x     <= '0;
              src_y     <= '0;
              finished  <= 1'b1;
            end else begin
              frame_now <= FRAME_W'(cur);
              tile_col  <= div_rsp.remainder;
              tile_row  <= div_rsp.quotient;
              src_x     <= px_x;
              src_y     <= px_y;
              finished  <= fin;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // accumulator stays within TIME_BITS bits while idle, once the advance loop is done
  a_accum_settled: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (accum[TIME_BITS] == 1'b0))
    else $error("time accumulator left above range");

  // frame ram is only written between transactions
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE))
    else $error("frame ram written while busy");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider result outside divide step");

  // a new result is loaded only when the output register is free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result overwrote pending transaction");
`endif

endmodule

// File: tb/sv/tb_top.sv
// testbench for the sprite frame sequencer: random frame writes, register settings and ticks against a predictor
`timescale 1ns / 100ps

module tb_top;
  import sfs_pkg::*;

  localparam int ITEMS         = 1450;
  localparam int PHASE_ITEMS   = 110;
  localparam int GUARD_STEPS   = 256;
  localparam int SETTLE_CYCLES = 40;
  localparam int GAP_MAX       = 5;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_now;
    logic [COL_W-1:0]   tile_col;
    logic [TILE_W-1:0]  tile_row;
    logic [SRCX_W-1:0]  src_x;
    logic [SRCY_W-1:0]  src_y;
    logic               finished;
  } frame_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [5:0]          idx;
    logic [TILE_W-1:0]   tile;
    logic [IN_DUR_W-1:0] dur;
    logic [IN_DUR_W-1:0] el;
  } item_t;

  class sprite_tracker;
    logic [IN_DUR_W-1:0] dur_tab[MAX_FRAMES_DEF];
    logic [TILE_W-1:0]   tile_tab[MAX_FRAMES_DEF];
    bit                  loaded[MAX_FRAMES_DEF];
    int unsigned         frame_cnt;
    int unsigned         columns;
    int unsigned         tile_w;
    int unsigned         tile_h;
    int unsigned         cur;
    int unsigned         accum;
    frame_t              frames_due[$];
    int unsigned         errors;

    function new();
      frame_cnt = FRAME_COUNT_RST;
      columns   = ATLAS_COLUMNS_RST;
      tile_w    = TILE_WIDTH_RST;
      tile_h    = TILE_HEIGHT_RST;
      cur       = 0;
      accum     = 0;
      errors    = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t r, int unsigned v);
      case (r)
        REG_FRAME_COUNT:   frame_cnt = v & 'h7f;
        REG_ATLAS_COLUMNS: columns   = v & 'hff;
        REG_TILE_WIDTH:    tile_w    = v & 'h1fff;
        REG_TILE_HEIGHT:   tile_h    = v & 'h1fff;
        default: ;
      endcase
    endfunction

    function int unsigned live_frames();
      return (frame_cnt > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frame_cnt;
    endfunction

    // runs one tick, returns the number of frame advances (stops past cap)
    function int unsigned advance(int unsigned el, bit commit, int unsigned cap,
                                  output frame_t res);
      int unsigned n, c, a, steps, cols, w, h, t, col, row;
      bit fin;
      n = live_frames();
      res = '0;
      steps = 0;
      fin = 1'b0;
      if (n == 0) begin
        res.finished = 1'b1;
        return 0;
      end
      c = (cur > n - 1) ? n - 1 : cur;
      a = accum + el;
      while (steps <= cap) begin
        if (a < dur_tab[c]) break;
        a -= dur_tab[c];
        c++;
        if (c >= n) begin
          c = 0;
          fin = 1'b1;
        end
        steps++;
      end
      if (commit) begin
        cur = c;
        accum = a;
      end
      cols = (columns == 0) ? 1 : columns;
      w = (tile_w > TILE_PX_MAX) ? TILE_PX_MAX : tile_w;
      h = (tile_h > TILE_PX_MAX) ? TILE_PX_MAX : tile_h;
      t = tile_tab[c];
      col = t % cols;
      row = t / cols;
      res.frame_now = FRAME_W'(c);
      res.tile_col  = COL_W'(col);
      res.tile_row  = TILE_W'(row);
      res.src_x     = SRCX_W'(col * w);
      res.src_y     = SRCY_W'(row * h);
      res.finished  = fin;
      return steps;
    endfunction

    function void take_item(item_t it);
      frame_t res;
      if (it.cmd == CMD_WRITE) begin
        tile_tab[it.idx] = it.tile;
        dur_tab[it.idx]  = (it.dur == 0) ? IN_DUR_W'(1) : it.dur;
        loaded[it.idx]   = 1'b1;
      end else begin
        void'(advance(it.el, 1'b1, 32'hffff_ffff, res));
        frames_due.push_back(res);
      end
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      bit bad;
      if (frames_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: frame %0d col %0d row %0d x %0d y %0d fin %0d",
                   got.frame_now, got.tile_col, got.tile_row, got.src_x, got.src_y,
                   got.finished);
        return;
      end
      want = frames_due.pop_front();
      bad = (got.frame_now !== want.frame_now) || (got.tile_col !== want.tile_col) ||
            (got.tile_row !== want.tile_row) || (got.src_x !== want.src_x) ||
            (got.src_y !== want.src_y) || (got.finished !== want.finished);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected frame %0d col %0d row %0d x %0d y %0d fin %0d",
                   want.frame_now, want.tile_col, want.tile_row, want.src_x, want.src_y,
                   want.finished);
          $display("          got      frame %0d col %0d row %0d x %0d y %0d fin %0d",
                   got.frame_now, got.tile_col, got.tile_row, got.src_x, got.src_y,
                   got.finished);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  cmd_t                  cmd;
  logic [5:0]            entry_index;
  logic [TILE_W-1:0]     entry_tile;
  logic [IN_DUR_W-1:0]   entry_duration;
  logic [IN_DUR_W-1:0]   elapsed;
  logic                  out_valid;
  logic                  out_ready;
  logic [FRAME_W-1:0]    frame_now;
  logic [COL_W-1:0]      tile_col;
  logic [TILE_W-1:0]     tile_row;
  logic [SRCX_W-1:0]     src_x;
  logic [SRCY_W-1:0]     src_y;
  logic                  finished;

  sprite_tracker tracker = new();
  bit            calm = 1'b0;
  bit            long_times = 1'b0;
  int            sent = 0;

  atlas_sprite_frame_sequencer_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .entry_index    (entry_index),
    .entry_tile     (entry_tile),
    .entry_duration (entry_duration),
    .elapsed        (elapsed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_now      (frame_now),
    .tile_col       (tile_col),
    .tile_row       (tile_row),
    .src_x          (src_x),
    .src_y          (src_y),
    .finished       (finished)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [IN_DUR_W-1:0] pick_duration();
    if (long_times)
      return ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom_range(16384, 65535));
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 4));
      2: return 16'($urandom);
      default: return 16'($urandom_range(8, 200));
    endcase
  endfunction

  function automatic logic [IN_DUR_W-1:0] pick_elapsed();
    if (long_times) return 16'($urandom);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic push_item(item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd            = it.cmd;
    entry_index    = it.idx;
    entry_tile     = it.tile;
    entry_duration = it.dur;
    elapsed        = it.el;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.take_item(it);
    sent++;
  endtask

  task automatic write_entry(int idx, int tile, int dur);
    item_t it;
    it.cmd  = CMD_WRITE;
    it.idx  = 6'(idx);
    it.tile = TILE_W'(tile);
    it.dur  = IN_DUR_W'(dur);
    it.el   = 16'($urandom);
    push_item(it);
  endtask

  task automatic write_random(int idx);
    write_entry(idx, $urandom_range(0, 4095), pick_duration());
  endtask

  task automatic tick(int unsigned el);
    item_t it;
    frame_t scratch;
    // keep the advance loop short so the run stays bounded
    while (el != 0 &&
           tracker.advance(el, 1'b0, GUARD_STEPS, scratch) > GUARD_STEPS) el = el >> 1;
    it.cmd  = CMD_TICK;
    it.idx  = 6'($urandom);
    it.tile = TILE_W'($urandom);
    it.dur  = 16'($urandom);
    it.el   = IN_DUR_W'(el);
    push_item(it);
  endtask

  task automatic settle(int extra);
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.frames_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t r, int unsigned v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = r;
    cfg_data  = CFG_W'(v);
    @(negedge clk);
    cfg_we    = 1'b0;
    tracker.set_reg(r, v);
  endtask

  task automatic run_phase(int p);
    int unsigned fc, cols, tw, th;
    case (p)
      0: begin fc = 64;  cols = 255; tw = 8191; th = 0;    end
      1: begin fc = 127; cols = 0;   tw = 0;    th = 8191; end
      2: begin fc = 1;   cols = 1;   tw = 4096; th = 1;    end
      3: begin fc = 0;   cols = 7;   tw = 1;    th = 4096; end
      4: begin fc = 2;   cols = 16;  tw = 32;   th = 32;   end
      default: begin
        case ($urandom_range(0, 9))
          0: fc = 0;
          1: fc = $urandom_range(65, 127);
          2, 3, 4: fc = $urandom_range(1, 64);
          default: fc = $urandom_range(1, 8);
        endcase
        cols = $urandom_range(0, 255);
        tw   = $urandom_range(0, 8191);
        th   = $urandom_range(0, 8191);
      end
    endcase
    calm       = (p % 4 == 3);
    long_times = (p % 3 == 1);
    settle(SETTLE_CYCLES);
    set_reg(REG_FRAME_COUNT, fc);
    set_reg(REG_ATLAS_COLUMNS, cols);
    set_reg(REG_TILE_WIDTH, tw);
    set_reg(REG_TILE_HEIGHT, th);
    for (int i = 0; i < int'(tracker.live_frames()); i++)
      if (!tracker.loaded[i]) write_random(i);
    for (int k = 0; k < PHASE_ITEMS && sent < ITEMS; k++) begin
      if ($urandom_range(0, 99) < 2) settle(0);
      if ($urandom_range(0, 99) < 40) write_random($urandom_range(0, 63));
      else tick(pick_elapsed());
    end
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_frame({frame_now, tile_col, tile_row, src_x, src_y, finished});
    end
  end

  initial begin
    int phase;
    cfg_we         = 1'b0;
    cfg_index      = REG_FRAME_COUNT;
    cfg_data       = '0;
    in_valid       = 1'b0;
    cmd            = CMD_WRITE;
    entry_index    = '0;
    entry_tile     = '0;
    entry_duration = '0;
    elapsed        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no frames after reset
    tick(0);
    write_entry(0, 0, 0);
    write_entry(1, 4095, 65535);
    write_entry(2, 1234, 3);
    write_entry(63, 4095, 0);
    settle(SETTLE_CYCLES);
    set_reg(REG_FRAME_COUNT, 3);
    tick(0);
    tick(1);
    tick(65535);
    tick(5);
    write_entry(0, 4095, 2);
    // index past count gets clamped, saturated width, zero height
    settle(SETTLE_CYCLES);
    set_reg(REG_FRAME_COUNT, 1);
    set_reg(REG_ATLAS_COLUMNS, 255);
    set_reg(REG_TILE_WIDTH, 8191);
    set_reg(REG_TILE_HEIGHT, 0);
    tick(0);
    tick(1);
    settle(SETTLE_CYCLES);
    set_reg(REG_FRAME_COUNT, 0);
    set_reg(REG_ATLAS_COLUMNS, 0);
    set_reg(REG_TILE_WIDTH, 4096);
    set_reg(REG_TILE_HEIGHT, 4096);
    tick(300);

    phase = 0;
    while (sent < ITEMS) begin
      run_phase(phase);
      phase++;
    end
    settle(SETTLE_CYCLES);
    if (tracker.errors == 0 && tracker.frames_due.size() == 0)
      $display("[atlas_sprite_frame_sequencer_unit] OK");
    else
      $display("[atlas_sprite_frame_sequencer_unit] ERROR");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("[atlas_sprite_frame_sequencer_unit] ERROR");
    $finish;
  end

endmodule
